[rtl/core/bcrs_pkg.sv]
// bcrs_pkg: shared types and constants of the chunk request sequencer
// holds the operation codes, result kinds and the job record passed front to back
// no dependencies
`timescale 1ns / 1ps

package bcrs_pkg;

  // operation codes of an input request
  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpBill  = 2'd1,
    OpTick  = 2'd2
  } op_e;

  // kind of a result
  typedef enum logic {
    MsgChunk = 1'b0,
    MsgEnd   = 1'b1
  } kind_e;

  localparam int unsigned BitmapWidth = 32;
  localparam int unsigned IndexWidth  = 32;
  localparam int unsigned RegionWidth = 27;
  localparam int unsigned ExpectWidth = 28;
  localparam int unsigned JobDepth    = 2;

  // one unit of work for the back end: chunks to send and an optional end message
  typedef struct packed {
    logic [BitmapWidth-1:0] mask;
    logic [IndexWidth-1:0]  base;
    logic                   end_flag;
  } job_t;

endpackage

[rtl/core/bcrs_front.sv]
// bcrs_front: session state and classification of incoming requests
// turns accepted requests into jobs for the back end; uses bcrs_pkg
`timescale 1ns / 1ps

module bcrs_front #(
  parameter int unsigned CHUNKS_PER_REGION = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [31:0]                         total_chunks_i,
  input  logic                                accept_i,
  input  logic [1:0]                          operation_i,
  input  logic [bcrs_pkg::RegionWidth-1:0]    bill_region_i,
  input  logic [bcrs_pkg::BitmapWidth-1:0]    bill_bitmap_i,
  output logic                                job_valid_o,
  output bcrs_pkg::job_t                      job_o
);

  localparam int unsigned ProdW = 33;

  logic                               active_q, active_d;
  logic                               seen_q, seen_d;
  logic [bcrs_pkg::ExpectWidth-1:0]   expect_q, expect_d;

  logic [ProdW-1:0]                   base;
  logic [ProdW-1:0]                   total;
  logic [ProdW-1:0]                   limit;
  logic                               in_range;
  logic                               is_final;
  logic [bcrs_pkg::BitmapWidth-1:0]   enable;
  logic [bcrs_pkg::BitmapWidth-1:0]   mask;

  // first chunk of the bill's region and room left below the total
  assign base  = ProdW'(bill_region_i) * ProdW'(CHUNKS_PER_REGION);
  assign total = ProdW'(total_chunks_i);
  assign limit = total - base;

  // region inside expected..final, final when fewer than a region remain
  assign in_range = active_q && (expect_q <= bcrs_pkg::ExpectWidth'(bill_region_i))
                    && (base <= total);
  assign is_final = in_range && (limit < ProdW'(CHUNKS_PER_REGION));

  // chunks that exist in this region
  always_comb begin
    for (int i = 0; i < bcrs_pkg::BitmapWidth; i++) begin
      enable[i] = (i < CHUNKS_PER_REGION) && (ProdW'(i) < limit);
    end
  end
  assign mask = bill_bitmap_i & enable;

  // session state update and job generation
  always_comb begin
    active_d    = active_q;
    seen_d      = seen_q;
    expect_d    = expect_q;
    job_valid_o = 1'b0;
    job_o.mask     = mask;
    job_o.base     = base[bcrs_pkg::IndexWidth-1:0];
    job_o.end_flag = is_final;
    if (accept_i) begin
      unique case (bcrs_pkg::op_e'(operation_i))
        bcrs_pkg::OpStart: begin
          if (!active_q) begin
            active_d = 1'b1;
            seen_d   = 1'b1;
            expect_d = '0;
          end
        end
        bcrs_pkg::OpBill: begin
          if (in_range) begin
            expect_d    = bcrs_pkg::ExpectWidth'(bill_region_i) + 1'b1;
            seen_d      = 1'b1;
            active_d    = !is_final;
            job_valid_o = (mask != '0) || is_final;
          end
        end
        bcrs_pkg::OpTick: begin
          seen_d = 1'b0;
          if (active_q && !seen_q) begin
            active_d       = 1'b0;
            job_valid_o    = 1'b1;
            job_o.mask     = '0;
            job_o.end_flag = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // session registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      seen_q   <= 1'b0;
      expect_q <= '0;
    end else begin
      active_q <= active_d;
      seen_q   <= seen_d;
      expect_q <= expect_d;
    end
  end

endmodule

[rtl/core/bcrs_job_fifo.sv]
// bcrs_job_fifo: short queue of jobs between front and back end
// register based, depth from bcrs_pkg; uses bcrs_pkg
`timescale 1ns / 1ps

module bcrs_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  bcrs_pkg::job_t wr_job_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           valid_o,
  output bcrs_pkg::job_t rd_job_o
);

  localparam int unsigned PtrW = (bcrs_pkg::JobDepth > 1) ? $clog2(bcrs_pkg::JobDepth) : 1;
  localparam int unsigned CntW = $clog2(bcrs_pkg::JobDepth + 1);

  bcrs_pkg::job_t        mem_q [bcrs_pkg::JobDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  do_wr, do_rd;

  assign full_o   = (count_q == CntW'(bcrs_pkg::JobDepth));
  assign valid_o  = (count_q != '0);
  assign rd_job_o = mem_q[rd_ptr_q];
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && valid_o;

  // storage, written at the tail
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(bcrs_pkg::JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(bcrs_pkg::JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/core/bcrs_back.sv]
// bcrs_back: walks a job's chunk mask; one result per cycle unless
// a result waits; holds the output result register; uses bcrs_pkg
`timescale 1ns / 1ps

module bcrs_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  input  bcrs_pkg::job_t                    job_i,
  output logic                              job_take_o,
  output logic                              out_valid_o,
  input  logic                              out_take_i,
  output logic                              message_kind_o,
  output logic [bcrs_pkg::IndexWidth-1:0]   chunk_index_o,
  output logic                              last_result_o
);

  localparam int unsigned BitW = $clog2(bcrs_pkg::BitmapWidth);

  logic                               busy_q;
  logic [bcrs_pkg::BitmapWidth-1:0]   mask_q, mask_d;
  logic [bcrs_pkg::IndexWidth-1:0]    base_q;
  logic                               end_q;

  logic                               out_valid_q;
  logic                               kind_q;
  logic [bcrs_pkg::IndexWidth-1:0]    index_q;
  logic                               last_q;

  logic                               emit;
  logic                               done;
  logic [BitW-1:0]                    low_bit;
  logic                               res_kind;
  logic [bcrs_pkg::IndexWidth-1:0]    res_index;
  logic                               res_last;

  // lowest pending chunk
  always_comb begin
    low_bit = '0;
    for (int i = bcrs_pkg::BitmapWidth - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_bit = BitW'(i);
      end
    end
  end

  // next result of the current job
  always_comb begin
    mask_d = mask_q;
    if (mask_q != '0) begin
      mask_d         = mask_q & (mask_q - 1'b1);
      res_kind  = bcrs_pkg::MsgChunk;
      res_index = base_q + bcrs_pkg::IndexWidth'(low_bit);
      res_last  = (mask_d == '0) && !end_q;
    end else begin
      res_kind  = bcrs_pkg::MsgEnd;
      res_index = '0;
      res_last  = 1'b1;
    end
  end

  assign emit       = busy_q && (!out_valid_q || out_take_i);
  assign done       = emit && res_last;
  assign job_take_o = job_valid_i && (!busy_q || done);

  // job walker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (job_take_o) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      mask_q <= job_i.mask;
      base_q <= job_i.base;
      end_q  <= job_i.end_flag;
    end else if (emit) begin
      mask_q <= mask_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_take_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= res_kind;
      index_q <= res_index;
      last_q  <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign message_kind_o = kind_q;
  assign chunk_index_o  = index_q;
  assign last_result_o  = last_q;

endmodule

[rtl/core/bill_to_chunk_request_sequencer.sv]
// bill_to_chunk_request_sequencer: top level of the chunk request sequencer
// ties front end, job queue and back end together; uses bcrs_pkg and the bcrs_* modules
`timescale 1ns / 1ps

// Usage
//   Input side is a queue: drive operation_i, bill_region_i, bill_bitmap_i with push;
//   a request is taken at a clock edge where push is high and full is low.
//   Output side is a queue: while empty is low a result sits on message_kind_o,
//   chunk_index_o and last_result_o; pop takes it. last_result_o marks the final
//   result of one request.
//   total_chunks is written over cfg_valid_i / cfg_ready_o / cfg_data_i; ready is
//   always high, write only while no work is outstanding.
// Timing
//   The front end decides a request in the cycle it is taken, so one request can be
//   taken every cycle while the job queue has room. The back end issues one result per
//   cycle unless a result waits for pop; a bill with n chunks and an optional end gives n or
//   n+1 results, 33 at most, sent on via the job queue, job register and result register.
// Reset and stalls
//   Reset ends the session, clears total_chunks and empties queue and result register.
//   When pop stays low the result register holds, the back end waits, the two-entry job
//   queue fills and then full goes high.
module bill_to_chunk_request_sequencer #(
  parameter int unsigned CHUNKS_PER_REGION = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        operation_i,
  input  logic [bcrs_pkg::RegionWidth-1:0]  bill_region_i,
  input  logic [bcrs_pkg::BitmapWidth-1:0]  bill_bitmap_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              message_kind_o,
  output logic [bcrs_pkg::IndexWidth-1:0]   chunk_index_o,
  output logic                              last_result_o
);

  logic [31:0]      total_chunks_q;
  logic             accept;
  logic             job_valid;
  bcrs_pkg::job_t   job_in;
  bcrs_pkg::job_t   job_head;
  logic             head_valid;
  logic             head_take;
  logic             out_valid;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_chunks_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      total_chunks_q <= cfg_data_i;
    end
  end

  // request accepted
  assign accept = push && !full;

  // front end
  bcrs_front #(
    .CHUNKS_PER_REGION(CHUNKS_PER_REGION)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_chunks_i (total_chunks_q),
    .accept_i       (accept),
    .operation_i    (operation_i),
    .bill_region_i  (bill_region_i),
    .bill_bitmap_i  (bill_bitmap_i),
    .job_valid_o    (job_valid),
    .job_o          (job_in)
  );

  // job queue
  bcrs_job_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_valid),
    .wr_job_i (job_in),
    .full_o   (full),
    .rd_en_i  (head_take),
    .valid_o  (head_valid),
    .rd_job_o (job_head)
  );

  // back end
  bcrs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (head_valid),
    .job_i          (job_head),
    .job_take_o     (head_take),
    .out_valid_o    (out_valid),
    .out_take_i     (pop),
    .message_kind_o (message_kind_o),
    .chunk_index_o  (chunk_index_o),
    .last_result_o  (last_result_o)
  );

  assign empty = !out_valid;

endmodule
